@@ sv/jacobi_3d_seven_point_sweep_macros.svh @@
// Assertion macros for the checker of the seven-point sweep block.
`ifndef JACOBI_3D_SEVEN_POINT_SWEEP_MACROS_SVH
`define JACOBI_3D_SEVEN_POINT_SWEEP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define JAC3D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define JAC3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jac3d_pkg.sv @@
// Shared constants, types and helpers of the seven-point sweep block.
package jac3d_pkg;

  // Grid geometry
  localparam int MAX_EDGE  = 32;
  localparam int EDGE_W    = $clog2(MAX_EDGE + 1);
  localparam int COL_W     = $clog2(MAX_EDGE);
  localparam int BANK_ROWS = (MAX_EDGE + 1) / 2;
  localparam int HALF_W    = $clog2(BANK_ROWS);
  localparam int ADDR_W    = HALF_W + COL_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  // Register field widths
  localparam int GRID_EDGE_W = 6;
  localparam int PAD_W       = 4;
  localparam int WEIGHT_W    = 16;
  localparam int CMP_W       = EDGE_W + PAD_W;

  // Arithmetic widths
  localparam int WORD_W = 32;
  localparam int SUM_W  = WORD_W + 3;
  localparam int PROD_W = SUM_W + WEIGHT_W + 1;
  localparam int FRAC_W = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_EDGE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT    = 2'd2;

  localparam logic [GRID_EDGE_W-1:0] GRID_EDGE_RESET = 6'd32;
  localparam logic [PAD_W-1:0]       PAD_WIDTH_RESET = 4'd1;
  localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET    = 16'd9372;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // One stencil job handed from the address front end to the datapath
  typedef struct packed {
    logic  valid;
    logic  pass;
    logic  last;
    logic  zpar;
    logic  rpar;
    word_t voxel;
  } issue_t;

  // Port requests for the four plane banks, indexed [plane parity][row parity]
  typedef struct packed {
    logic                  re;
    logic [1:0][1:0]       we;
    addr_t                 waddr;
    word_t                 wdata;
    addr_t [1:0][1:0]      raddr0;
    addr_t [1:0][1:0]      raddr1;
  } mem_req_t;

  function automatic sum_t sext_word(input word_t w);
    return {{(SUM_W - WORD_W){w[WORD_W-1]}}, w};
  endfunction

endpackage

@@ sv/jacobi_3d_seven_point_sweep.sv @@
// Top level of the seven-point Jacobi sweep over a streamed cubic grid.
//
//   channel   direction  handshake                    payload
//   cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//   in        in         in_valid / in_ready          voxel_value, drain
//   result    out        result_valid / result_ready  result_value, passed_through,
//                                                     last_of_grid
//
// One beat per cycle on in while in_ready is high; each sweep beat issues all bank
// reads and, unless it drains, the write at once. The voxel a beat releases passes
// through bank read, sum, multiply, round and saturate into the output register.
// Reset clears counters and stage valids and presets config registers; plane banks keep data.
// With result_ready low, in_ready drops once every stage and the output are full.
module jacobi_3d_seven_point_sweep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jac3d_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jac3d_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [jac3d_pkg::WORD_W-1:0]  voxel_value,
  input  logic                                 drain,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [jac3d_pkg::WORD_W-1:0]  result_value,
  output logic                                 passed_through,
  output logic                                 last_of_grid
);

  jac3d_pkg::issue_t            issue;
  jac3d_pkg::mem_req_t          mem_req;
  jac3d_pkg::word_t [1:0][1:0]  rdata0;
  jac3d_pkg::word_t [1:0][1:0]  rdata1;
  logic [jac3d_pkg::WEIGHT_W-1:0] weight;
  logic                         free;

  jac3d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .voxel_value (voxel_value),
    .drain       (drain),
    .free        (free),
    .weight      (weight),
    .issue       (issue),
    .mem_req     (mem_req)
  );

  // Plane banks: [plane parity][row parity]
  for (genvar q = 0; q < 2; q++) begin : g_plane
    for (genvar b = 0; b < 2; b++) begin : g_bank
      jac3d_ram #(
        .WIDTH (jac3d_pkg::WORD_W),
        .DEPTH (jac3d_pkg::RAM_DEPTH)
      ) u_ram (
        .clk    (clk),
        .we     (mem_req.we[q][b]),
        .waddr  (mem_req.waddr),
        .wdata  (mem_req.wdata),
        .re     (mem_req.re),
        .raddr0 (mem_req.raddr0[q][b]),
        .raddr1 (mem_req.raddr1[q][b]),
        .rdata0 (rdata0[q][b]),
        .rdata1 (rdata1[q][b])
      );
    end
  end

  jac3d_core u_core (
    .clk            (clk),
    .rst            (rst),
    .issue          (issue),
    .rdata0         (rdata0),
    .rdata1         (rdata1),
    .weight         (weight),
    .free           (free),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_value   (result_value),
    .passed_through (passed_through),
    .last_of_grid   (last_of_grid)
  );

endmodule

@@ sv/jac3d_ram.sv @@
// Generic RAM: one write port, two registered read ports, read before write.
module jac3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and hold read data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ sv/jac3d_front.sv @@
// Registers, raster counters, border test and bank addressing of the sweep.
module jac3d_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jac3d_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jac3d_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [jac3d_pkg::WORD_W-1:0] voxel_value,
  input  logic                                drain,
  input  logic                                free,
  output logic [jac3d_pkg::WEIGHT_W-1:0]      weight,
  output jac3d_pkg::issue_t                   issue,
  output jac3d_pkg::mem_req_t                 mem_req
);

  logic [jac3d_pkg::GRID_EDGE_W-1:0] grid_edge;
  logic [jac3d_pkg::PAD_W-1:0]       pad_width;

  logic [jac3d_pkg::EDGE_W-1:0] in_plane;
  logic [jac3d_pkg::EDGE_W-1:0] in_row;
  logic [jac3d_pkg::EDGE_W-1:0] in_col;

  logic [jac3d_pkg::EDGE_W-1:0] edge_len;
  logic [jac3d_pkg::EDGE_W-1:0] edge_m1;
  logic [jac3d_pkg::PAD_W-1:0]  pad_len;
  logic [jac3d_pkg::EDGE_W-1:0] z_pos;
  logic [jac3d_pkg::CMP_W-1:0]  e_c, p_c, hi_c, z_c, r_c, c_c;

  logic cfg_take, restart;
  logic draining, act, emit, pass, last;
  logic col_end, row_end;
  logic rpar, ppar, zpar;

  logic [jac3d_pkg::HALF_W-1:0] half_r, half_up, half_dn;
  logic [jac3d_pkg::COL_W-1:0]  col, col_e;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign restart   = cfg_take & (cfg_index == jac3d_pkg::REG_GRID_EDGE);
  assign in_ready  = free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_edge <= jac3d_pkg::GRID_EDGE_RESET;
      pad_width <= jac3d_pkg::PAD_WIDTH_RESET;
      weight    <= jac3d_pkg::WEIGHT_RESET;
    end else if (cfg_take) begin
      unique case (cfg_index)
        jac3d_pkg::REG_GRID_EDGE: grid_edge <= cfg_data[jac3d_pkg::GRID_EDGE_W-1:0];
        jac3d_pkg::REG_PAD_WIDTH: pad_width <= cfg_data[jac3d_pkg::PAD_W-1:0];
        jac3d_pkg::REG_WEIGHT:    weight    <= cfg_data[jac3d_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the edge and the pad to their usable ranges
  always_comb begin
    if (int'(grid_edge) < 3) begin
      edge_len = jac3d_pkg::EDGE_W'(3);
    end else if (int'(grid_edge) > jac3d_pkg::MAX_EDGE) begin
      edge_len = jac3d_pkg::EDGE_W'(jac3d_pkg::MAX_EDGE);
    end else begin
      edge_len = jac3d_pkg::EDGE_W'(grid_edge);
    end
    pad_len = (pad_width == '0) ? jac3d_pkg::PAD_W'(1) : pad_width;
    edge_m1 = edge_len - jac3d_pkg::EDGE_W'(1);
  end

  // Classify the beat and test the released voxel against the border
  always_comb begin
    draining = (in_plane >= edge_len);
    act      = in_valid & in_ready & (draining == drain);
    emit     = drain | (in_plane != '0);
    z_pos    = in_plane - jac3d_pkg::EDGE_W'(1);
    e_c      = jac3d_pkg::CMP_W'(edge_len);
    p_c      = jac3d_pkg::CMP_W'(pad_len);
    hi_c     = (e_c > p_c) ? e_c - p_c : '0;
    z_c      = jac3d_pkg::CMP_W'(z_pos);
    r_c      = jac3d_pkg::CMP_W'(in_row);
    c_c      = jac3d_pkg::CMP_W'(in_col);
    pass     = (z_c < p_c) | (z_c >= hi_c) | (r_c < p_c) | (r_c >= hi_c)
             | (c_c < p_c) | (c_c >= hi_c);
    last     = drain & (in_row == edge_m1) & (in_col == edge_m1);
    col_end  = (in_col == edge_m1);
    row_end  = (in_row == edge_m1);
  end

  // Advance the raster position; a grid edge write starts a new sweep
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_plane <= '0;
      in_row   <= '0;
      in_col   <= '0;
    end else if (act) begin
      if (col_end) begin
        in_col <= '0;
        if (row_end) begin
          in_row <= '0;
          in_plane <= drain ? '0 : in_plane + jac3d_pkg::EDGE_W'(1);
        end else begin
          in_row <= in_row + jac3d_pkg::EDGE_W'(1);
        end
      end else begin
        in_col <= in_col + jac3d_pkg::EDGE_W'(1);
      end
    end
  end

  // Bank addressing: even and odd planes, each split by row parity
  always_comb begin
    rpar    = in_row[0];
    ppar    = in_plane[0];
    zpar    = ~in_plane[0];
    half_r  = jac3d_pkg::HALF_W'(in_row >> 1);
    half_up = jac3d_pkg::HALF_W'((in_row - jac3d_pkg::EDGE_W'(1)) >> 1);
    half_dn = jac3d_pkg::HALF_W'((in_row + jac3d_pkg::EDGE_W'(1)) >> 1);
    col     = jac3d_pkg::COL_W'(in_col);
    col_e   = jac3d_pkg::COL_W'(in_col + jac3d_pkg::EDGE_W'(1));

    mem_req.re    = act;
    mem_req.waddr = {half_r, col};
    mem_req.wdata = voxel_value;
    for (int q = 0; q < 2; q++) begin
      for (int b = 0; b < 2; b++) begin
        // Rows above and below share the bank of the other row parity
        if ((1'(q) == zpar) && (1'(b) != rpar)) begin
          mem_req.raddr0[q][b] = {half_up, col};
          mem_req.raddr1[q][b] = {half_dn, col};
        end else begin
          mem_req.raddr0[q][b] = {half_r, col};
          mem_req.raddr1[q][b] = {half_r, col_e};
        end
        mem_req.we[q][b] = act & ~drain & (1'(q) == ppar) & (1'(b) == rpar);
      end
    end
  end

  // Hand the released voxel to the datapath
  always_comb begin
    issue.valid = act & emit;
    issue.pass  = pass;
    issue.last  = last;
    issue.zpar  = zpar;
    issue.rpar  = rpar;
    issue.voxel = voxel_value;
  end

endmodule

@@ sv/jac3d_core.sv @@
// Stencil datapath: gather, sum, scale, round and saturate, with output register.
module jac3d_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  jac3d_pkg::issue_t                    issue,
  input  jac3d_pkg::word_t [1:0][1:0]          rdata0,
  input  jac3d_pkg::word_t [1:0][1:0]          rdata1,
  input  logic [jac3d_pkg::WEIGHT_W-1:0]       weight,
  output logic                                 free,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [jac3d_pkg::WORD_W-1:0]  result_value,
  output logic                                 passed_through,
  output logic                                 last_of_grid
);

  localparam int SCALED_W = jac3d_pkg::PROD_W - jac3d_pkg::FRAC_W;
  localparam int TOP_W    = SCALED_W - jac3d_pkg::WORD_W + 1;

  jac3d_pkg::issue_t s1;
  logic              s1_valid, s2_valid, s3_valid;
  logic              s1_go, s2_go, s3_go;

  jac3d_pkg::word_t  prev_center;
  jac3d_pkg::word_t  center, east, north, south, below;
  jac3d_pkg::sum_t   sum;

  jac3d_pkg::sum_t   s2_sum;
  jac3d_pkg::word_t  s2_center;
  logic              s2_pass, s2_last;

  jac3d_pkg::prod_t  s3_prod;
  jac3d_pkg::word_t  s3_center;
  logic              s3_pass, s3_last;

  jac3d_pkg::prod_t          rounded;
  logic [SCALED_W-1:0]       scaled;
  logic [TOP_W-1:0]          top_bits;
  jac3d_pkg::word_t          sat;

  // Stage handshakes: a stage moves when the next one is empty or moving
  assign s3_go = s3_valid & (~result_valid | result_ready);
  assign s2_go = s2_valid & (~s3_valid | s3_go);
  assign s1_go = s1_valid & (~s2_valid | s2_go);
  assign free  = ~s1_valid | s1_go;

  // Pick five of the seven stencil points out of the bank read data and sum all seven
  always_comb begin
    center = rdata0[s1.zpar][s1.rpar];
    east   = rdata1[s1.zpar][s1.rpar];
    north  = rdata0[s1.zpar][~s1.rpar];
    south  = rdata1[s1.zpar][~s1.rpar];
    below  = rdata0[~s1.zpar][s1.rpar];
    sum    = jac3d_pkg::sext_word(center) + jac3d_pkg::sext_word(prev_center)
           + jac3d_pkg::sext_word(east)   + jac3d_pkg::sext_word(north)
           + jac3d_pkg::sext_word(south)  + jac3d_pkg::sext_word(below)
           + jac3d_pkg::sext_word(s1.voxel);
  end

  // Round half up, then clamp to the signed word range
  always_comb begin
    rounded  = s3_prod + (jac3d_pkg::prod_t'(1) <<< (jac3d_pkg::FRAC_W - 1));
    scaled   = rounded[jac3d_pkg::PROD_W-1:jac3d_pkg::FRAC_W];
    top_bits = scaled[SCALED_W-1:jac3d_pkg::WORD_W-1];
    if ((&top_bits) || (~|top_bits)) begin
      sat = scaled[jac3d_pkg::WORD_W-1:0];
    end else if (scaled[SCALED_W-1]) begin
      sat = {1'b1, {(jac3d_pkg::WORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(jac3d_pkg::WORD_W-1){1'b1}}};
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= issue.valid | (s1_valid & ~s1_go);
      s2_valid     <= s1_go | (s2_valid & ~s2_go);
      s3_valid     <= s2_go | (s3_valid & ~s3_go);
      result_valid <= s3_go | (result_valid & ~result_ready);
    end
  end

  // Stage payloads; the center of the previous voxel is the west neighbor
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1 <= issue;
    end
    if (s1_go) begin
      prev_center <= center;
      s2_sum      <= sum;
      s2_center   <= center;
      s2_pass     <= s1.pass;
      s2_last     <= s1.last;
    end
    if (s2_go) begin
      s3_prod   <= s2_sum * $signed({1'b0, weight});
      s3_center <= s2_center;
      s3_pass   <= s2_pass;
      s3_last   <= s2_last;
    end
    if (s3_go) begin
      result_value   <= s3_pass ? s3_center : sat;
      passed_through <= s3_pass;
      last_of_grid   <= s3_last;
    end
  end

endmodule

@@ sv/jac3d_checker.sv @@
// Port-level checker of the seven-point sweep, bound to the top level.
`include "jacobi_3d_seven_point_sweep_macros.svh"

module jac3d_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic signed [jac3d_pkg::WORD_W-1:0] result_value,
  input logic                                passed_through,
  input logic                                last_of_grid
);

  // With result_ready high every stage can move, so the input side must be open
  `JAC3D_ASSERT_NOW(a_ready_when_drained, result_ready, in_ready, "in_ready low while result_ready high")

  // The final voxel of a sweep always lies in the border
  `JAC3D_ASSERT_NOW(a_last_is_border, result_valid && last_of_grid, passed_through, "last voxel not passed through")

  // Hold a stalled result beat
  `JAC3D_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_value) && $stable(passed_through) && $stable(last_of_grid), "stalled result beat changed")

  // A trivially true check that keeps the input valid visibly part of the check set
  `JAC3D_ASSERT_NOW(a_in_beat_sane, in_valid && in_ready && result_ready, in_ready, "input beat lost ready")

endmodule

bind jacobi_3d_seven_point_sweep jac3d_checker u_checker (.*);

@@ bench/jacobi_3d_seven_point_sweep_test.sv @@
// Self-checking bench for the streamed seven-point Jacobi sweep block.
module jacobi_3d_seven_point_sweep_test;
  import jac3d_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PLANE_WORDS = MAX_EDGE * MAX_EDGE;
  localparam int LONG_HOLD = 80;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     flush;
    bit                       after_idle;
  } sweep_item_t;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     pass;
    logic                     last;
  } voxel_out_t;

  typedef struct {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WORD_W-1:0] voxel_value = '0;
  logic drain = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [WORD_W-1:0] result_value;
  logic passed_through;
  logic last_of_grid;

  // Stimulus queues and handshake bookkeeping
  sweep_item_t feed[$];
  reg_write_t reg_writes[$];
  voxel_out_t due_voxels[$];
  voxel_out_t want_next;
  int voxels_unaccepted = 0;
  int writes_unaccepted = 0;
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;
  int mismatches = 0;

  // Idling controls, set per phase
  int gap_pct = 0;
  int sink_pct = 0;
  bit long_hold_req = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;

  // Mirror of the block: registers, plane store and sweep position
  logic [GRID_EDGE_W-1:0] edge_reg = GRID_EDGE_RESET;
  logic [PAD_W-1:0] pad_reg = PAD_WIDTH_RESET;
  logic [WEIGHT_W-1:0] weight_reg = WEIGHT_RESET;
  logic signed [WORD_W-1:0] grid_planes [0:2*PLANE_WORDS-1];
  int at_plane = 0;
  int at_row = 0;
  int at_col = 0;
  int released = 0;

  // Stimulus side view of the sweep, to keep sequences well formed
  int gen_edge = 32;
  int vox_left = 0;
  int drains_left = 0;
  int fed = 0;

  jacobi_3d_seven_point_sweep uut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int edge_of(input logic [GRID_EDGE_W-1:0] g);
    if (g < 3) return 3;
    if (g > MAX_EDGE) return MAX_EDGE;
    return int'(g);
  endfunction

  function automatic int slot(input int pl, input int rw, input int cl);
    return (pl & 1) * PLANE_WORDS + rw * MAX_EDGE + cl;
  endfunction

  task automatic rewind_sweep();
    at_plane = 0;
    at_row = 0;
    at_col = 0;
    released = 0;
  endtask

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GRID_EDGE: begin
        edge_reg = data[GRID_EDGE_W-1:0];
        rewind_sweep();
      end
      REG_PAD_WIDTH: pad_reg = data[PAD_W-1:0];
      REG_WEIGHT: weight_reg = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Advance the mirrored sweep by one beat and queue the voxel it releases
  task automatic sweep_voxel(input logic signed [WORD_W-1:0] v, input logic flush);
    int e, p, z, r, c, hi;
    bit emit, pass;
    logic signed [WORD_W-1:0] below, got;
    longint sum, scaled;
    e = edge_of(edge_reg);
    p = (pad_reg == 0) ? 1 : int'(pad_reg);
    r = at_row;
    c = at_col;
    below = '0;
    // drop voxels while flushing and flushes while the grid is still arriving
    if ((at_plane >= e) != flush) return;
    if (flush) begin
      z = e - 1;
      emit = 1'b1;
    end else begin
      emit = at_plane >= 1;
      z = emit ? at_plane - 1 : at_plane;
      below = grid_planes[slot(at_plane, r, c)];
      grid_planes[slot(at_plane, r, c)] = v;
    end
    if (emit) begin
      hi = (e > p) ? e - p : 0;
      pass = z < p || z >= hi || r < p || r >= hi || c < p || c >= hi;
      if (pass) begin
        got = grid_planes[slot(z, r, c)];
      end else begin
        sum = longint'(grid_planes[slot(z, r, c)])
            + longint'(grid_planes[slot(z, r - 1, c)])
            + longint'(grid_planes[slot(z, r + 1, c)])
            + longint'(grid_planes[slot(z, r, c - 1)])
            + longint'(grid_planes[slot(z, r, c + 1)])
            + longint'(below) + longint'(v);
        // round half up, then clamp to the Q15.16 range
        scaled = (sum * longint'(weight_reg) + 64'sd32768) >>> FRAC_W;
        if (scaled > 64'sd2147483647) got = 32'sh7FFFFFFF;
        else if (scaled < -64'sd2147483648) got = 32'sh80000000;
        else got = scaled[WORD_W-1:0];
      end
      due_voxels.push_back('{got, pass, (released + 1 == e * e * e)});
      released++;
    end
    at_col++;
    if (at_col >= e) begin
      at_col = 0;
      at_row++;
      if (at_row >= e) begin
        at_row = 0;
        if (flush) rewind_sweep();
        else at_plane++;
      end
    end
  endtask

  // Sample beats on all three channels and check results in order
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        writes_unaccepted--;
      end
      if (in_valid && in_ready) begin
        sweep_voxel(voxel_value, drain);
        voxels_unaccepted--;
      end
      if (result_valid && result_ready) begin
        if (due_voxels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %h pass %b last %b",
                     result_value, passed_through, last_of_grid);
        end else begin
          want_next = due_voxels.pop_front();
          if (result_value !== want_next.value || passed_through !== want_next.pass ||
              last_of_grid !== want_next.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                       want_next.value, want_next.pass, want_next.last,
                       result_value, passed_through, last_of_grid);
          end
        end
      end
    end
  end

  // Input driver: hold a beat until taken, idle in bursts, honor pause points
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap--;
      in_valid <= 1'b0;
    end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      src_gap = $urandom_range(0, 5);
      in_valid <= 1'b0;
    end else if (feed.size() != 0 && !(feed[0].after_idle && due_voxels.size() != 0)) begin
      in_valid <= 1'b1;
      voxel_value <= feed[0].value;
      drain <= feed[0].flush;
      void'(feed.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      result_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      result_ready <= 1'b0;
    end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
      sink_gap = $urandom_range(0, 5);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Register write driver
  always @(negedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && !cfg_took) begin
      cfg_valid <= 1'b1;
    end else if (reg_writes.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_writes[0].index;
      cfg_data <= reg_writes[0].data;
      void'(reg_writes.pop_front());
    end else begin
      cfg_valid <= 1'b0;
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_value();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case (raw[2:0])
          3'd0: return 32'sh7FFFFFFF;
          3'd1: return 32'sh80000000;
          3'd2: return '0;
          3'd3: return 32'shFFFFFFFF;
          default: return 32'sh00000001;
        endcase
      end
      1, 2: return {{12{raw[31]}}, raw[19:0]};
      3: return {2'b01, raw[29:0]};
      4: return {2'b10, raw[29:0]};
      default: return raw;
    endcase
  endfunction

  task automatic send(input logic signed [WORD_W-1:0] v, input logic flush,
                      input bit after_idle);
    feed.push_back('{v, flush, after_idle});
    voxels_unaccepted++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    reg_writes.push_back('{idx, data});
    writes_unaccepted++;
  endtask

  task automatic commit_writes();
    while (writes_unaccepted != 0) @(negedge clk);
  endtask

  // Wait until every beat is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (voxels_unaccepted != 0 || due_voxels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Feed n counted beats along the sweep, with stray beats of the wrong kind mixed in
  task automatic run_chunk(input int n, input bit tally);
    while (n > 0) begin
      if (vox_left == 0 && drains_left == 0) begin
        vox_left = gen_edge * gen_edge * gen_edge;
        drains_left = gen_edge * gen_edge;
      end
      if ($urandom_range(0, 29) == 0) begin
        send(pick_value(), (vox_left != 0), 1'b0);
      end else begin
        if (vox_left > 0) begin
          send(pick_value(), 1'b0, ($urandom_range(0, 59) == 0));
          vox_left--;
        end else begin
          send(pick_value(), 1'b1, ($urandom_range(0, 59) == 0));
          drains_left--;
        end
        n--;
        if (tally) fed++;
      end
    end
  endtask

  initial begin
    int phase, z, r, c;
    logic [31:0] raw;
    foreach (grid_planes[i]) grid_planes[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: smallest grid, thinnest pad, full weight; saturate the centre low
    write_reg(REG_GRID_EDGE, 16'h0000);
    write_reg(REG_PAD_WIDTH, 16'h0000);
    write_reg(REG_WEIGHT, 16'hFFFF);
    commit_writes();
    gen_edge = 3;
    vox_left = 27;
    drains_left = 9;
    send(32'sh7FFFFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 23; i++) begin
      z = i / 9;
      r = (i / 3) % 3;
      c = i % 3;
      if (i == 0) send('0, 1'b0, 1'b0);
      else if (i == 1) send(32'shFFFFFFFF, 1'b0, 1'b0);
      else if (i == 2) send(32'sh00000001, 1'b0, 1'b0);
      else if ((z == 1 && ((r == 1) || (c == 1)) && !(r != 1 && c != 1) &&
                (r + c >= 1) && (r + c <= 3) && (r == 1 || c == 1) &&
                !((r == 0 || r == 2) && (c == 0 || c == 2))) ||
               ((z == 0 || z == 2) && r == 1 && c == 1))
        send(32'sh80000000, 1'b0, 1'b0);
      else send(32'sh7FFFFFFF, 1'b0, 1'b0);
    end
    vox_left = 4;
    settle();

    // Random phases: registers rewritten between phases while idle
    phase = 0;
    while (fed < 1450) begin
      if (fed > 1200) begin
        gap_pct = 0;
        sink_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 8;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: sink_pct = 0;
          1: sink_pct = 8;
          default: sink_pct = 30;
        endcase
      end
      raw = $urandom;
      if (phase == 5) begin
        // largest grid, reached by a value beyond the clamp
        raw[GRID_EDGE_W-1:0] = 6'd63;
        write_reg(REG_GRID_EDGE, raw[CFG_DATA_W-1:0]);
        gen_edge = MAX_EDGE;
        vox_left = 0;
        drains_left = 0;
      end else if (phase == 6 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: raw[GRID_EDGE_W-1:0] = 6'($urandom_range(0, 2));
          1, 2: raw[GRID_EDGE_W-1:0] = 6'($urandom_range(7, 9));
          default: raw[GRID_EDGE_W-1:0] = 6'($urandom_range(3, 6));
        endcase
        write_reg(REG_GRID_EDGE, raw[CFG_DATA_W-1:0]);
        gen_edge = edge_of(raw[GRID_EDGE_W-1:0]);
        vox_left = 0;
        drains_left = 0;
      end
      if ($urandom_range(0, 1) == 0) begin
        raw = $urandom;
        case ($urandom_range(0, 4))
          0: raw[PAD_W-1:0] = 4'd0;
          1: raw[PAD_W-1:0] = 4'd15;
          2: raw[PAD_W-1:0] = 4'($urandom_range(0, 15));
          default: raw[PAD_W-1:0] = 4'($urandom_range(1, 2));
        endcase
        write_reg(REG_PAD_WIDTH, raw[CFG_DATA_W-1:0]);
      end
      if ($urandom_range(0, 1) == 0) begin
        raw = $urandom;
        case ($urandom_range(0, 4))
          0: raw[WEIGHT_W-1:0] = '0;
          1: raw[WEIGHT_W-1:0] = 16'hFFFF;
          2: raw[WEIGHT_W-1:0] = WEIGHT_RESET;
          default: ;
        endcase
        write_reg(REG_WEIGHT, raw[CFG_DATA_W-1:0]);
      end
      if ($urandom_range(0, 7) == 0) begin
        raw = $urandom;
        write_reg(REG_UNUSED, raw[CFG_DATA_W-1:0]);
      end
      commit_writes();
      // stall the result side for a long stretch while beats keep coming
      if (phase == 2 || (fed <= 1200 && $urandom_range(0, 9) == 0)) begin
        gap_pct = 0;
        long_hold_req = 1'b1;
      end
      if (phase == 5) run_chunk(PLANE_WORDS + 70, 1'b0);
      else run_chunk($urandom_range(20, 160), 1'b1);
      settle();
      phase++;
    end

    while (voxels_unaccepted != 0 || due_voxels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/jac3d_pkg.sv
sv/jac3d_ram.sv
sv/jac3d_front.sv
sv/jac3d_core.sv
sv/jacobi_3d_seven_point_sweep.sv
sv/jac3d_checker.sv
bench/jacobi_3d_seven_point_sweep_test.sv
